// ===== hdl/aegt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aegt_pkg;

    localparam int SKIP_W = 17;
    localparam int MIN_W  = 8;
    localparam logic [MIN_W-1:0] MIN_BASE_RUN_RESET = 8'd16;

    typedef enum logic [1:0] {
        PH_LEAD = 2'd0,
        PH_BASE = 2'd1,
        PH_GAP  = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    typedef struct packed {
        logic is_gap;
        logic last_column;
    } t_in_item;

    typedef struct packed {
        logic [SKIP_W-1:0] skip_count;
        logic              all_trimmed;
        logic              too_long;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hdl/alignment_end_gap_trimmer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// alignment end-gap trimmer
// input channel: one template column per item (is_gap, last_column), valid/stall
// output channel: one result item (skip_count, all_trimmed, too_long) per alignment,
//   issued only for the column flagged last_column
// config: i_cfg_we / i_cfg_data write min_base_run (reset 16); write only while idle
// path: a last column passes the input register, then one pass of counter/compare logic
//   into the result register, which it enters once the result slot is free
// throughput: one column per cycle, sustained, while the receiver takes results;
//   the rate is set by the per-column state update in the scan unit
// reset: synchronous active-low; clears stream state and the valid bits of both
//   registers, restores min_base_run to 16; no clearing pass
// stall: a held result stalls the scan stage, and the input register then raises
//   o_in_stall; nothing is lost or repeated; feed columns reversed to trim the tail
module alignment_end_gap_trimmer_core
    import aegt_pkg::*;
#(
    parameter int MAX_COLUMNS = 65536
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_item,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_item,
    input  wire logic             i_cfg_we,
    input  wire logic [MIN_W-1:0] i_cfg_data
);

    logic             r_in_valid;
    t_in_item         r_in_item;
    logic             r_out_valid;
    t_out_item        r_out_item;
    logic [MIN_W-1:0] r_min_base_run;

    logic      w_accept;
    logic      w_fire;
    t_out_item w_result;

    // scan stage moves when the result slot is free or being emptied
    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;

    // stream state and per-column update
    aegt_scan #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_item         (r_in_item),
        .i_min_base_run (r_min_base_run),
        .o_result       (w_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item <= i_in_item;
        end
    end

    // result register, loaded only by a last column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_item.last_column) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_item.last_column) begin
            r_out_item <= w_result;
        end
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_base_run <= MIN_BASE_RUN_RESET;
        end else if (i_cfg_we) begin
            r_min_base_run <= i_cfg_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ===== hdl/aegt_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aegt_scan
    import aegt_pkg::*;
#(
    parameter int MAX_COLUMNS = 65536
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire t_in_item         i_item,
    input  wire logic [MIN_W-1:0] i_min_base_run,
    output t_out_item             o_result
);

    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int LW = (CW > MIN_W) ? CW : MIN_W;
    localparam int XW = (CW > SKIP_W) ? CW : SKIP_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_COLUMNS);

    logic [CW-1:0] r_column_count, n_column_count;
    logic [CW-1:0] r_run_start, n_run_start;
    logic [CW-1:0] r_base_len, n_base_len;
    logic [CW-1:0] r_gap_len, n_gap_len;
    t_phase        r_phase, n_phase;
    logic          r_overflow, n_overflow;

    logic          w_trim_now;
    logic          w_trim_next;
    logic [CW-1:0] w_skip;
    logic [XW-1:0] w_skip_x;

    // pair test on the state before this column
    assign w_trim_now = (LW'(r_base_len) < LW'(i_min_base_run)) || (r_base_len < r_gap_len);

    always_comb begin
        n_column_count = r_column_count;
        n_run_start    = r_run_start;
        n_base_len     = r_base_len;
        n_gap_len      = r_gap_len;
        n_phase        = r_phase;
        n_overflow     = r_overflow;
        if (r_column_count < MAX_CNT) begin
            n_column_count = r_column_count + 1'b1;
            unique case (r_phase)
                PH_LEAD: begin
                    if (!i_item.is_gap) begin
                        n_run_start = r_column_count;
                        n_base_len  = CW'(1);
                        n_gap_len   = '0;
                        n_phase     = PH_BASE;
                    end
                end
                PH_BASE: begin
                    if (i_item.is_gap) begin
                        n_gap_len = CW'(1);
                        n_phase   = PH_GAP;
                    end else begin
                        n_base_len = r_base_len + 1'b1;
                    end
                end
                PH_GAP: begin
                    if (i_item.is_gap) begin
                        n_gap_len = r_gap_len + 1'b1;
                    end else if (w_trim_now) begin
                        n_run_start = r_column_count;
                        n_base_len  = CW'(1);
                        n_gap_len   = '0;
                        n_phase     = PH_BASE;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            n_overflow = 1'b1;
        end
    end

    assign w_trim_next = (LW'(n_base_len) < LW'(i_min_base_run)) || (n_base_len < n_gap_len);

    always_comb begin
        if (n_phase == PH_DONE) begin
            w_skip = n_run_start;
        end else if (n_phase == PH_LEAD || w_trim_next) begin
            w_skip = n_column_count;
        end else begin
            w_skip = n_run_start;
        end
    end

    assign w_skip_x             = XW'(w_skip);
    assign o_result.skip_count  = w_skip_x[SKIP_W-1:0];
    assign o_result.all_trimmed = (w_skip == n_column_count);
    assign o_result.too_long    = n_overflow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count <= '0;
            r_run_start    <= '0;
            r_base_len     <= '0;
            r_gap_len      <= '0;
            r_phase        <= PH_LEAD;
            r_overflow     <= 1'b0;
        end else if (i_fire) begin
            if (i_item.last_column) begin
                r_column_count <= '0;
                r_run_start    <= '0;
                r_base_len     <= '0;
                r_gap_len      <= '0;
                r_phase        <= PH_LEAD;
                r_overflow     <= 1'b0;
            end else begin
                r_column_count <= n_column_count;
                r_run_start    <= n_run_start;
                r_base_len     <= n_base_len;
                r_gap_len      <= n_gap_len;
                r_phase        <= n_phase;
                r_overflow     <= n_overflow;
            end
        end
    end

endmodule

`default_nettype wire
